// ===== rtl/core/rfhc_pkg.sv =====
package rfhc_pkg;

  localparam int unsigned HEADER_BYTES = 22;
  localparam int unsigned POS_W        = $clog2(HEADER_BYTES);
  localparam int unsigned CNT_W        = 64;
  localparam int unsigned FIXED_W      = 34;
  localparam int unsigned ADDR_W       = 5;
  localparam int unsigned DATA_W       = 32;

  // Byte offsets of the little-endian header fields
  localparam int unsigned OFS_VERSION = 0;
  localparam int unsigned OFS_TYPE    = 1;
  localparam int unsigned OFS_CTRL    = 2;
  localparam int unsigned OFS_NAME    = 6;
  localparam int unsigned OFS_ERROR   = 10;
  localparam int unsigned OFS_PAYLOAD = 14;

  typedef enum logic [2:0] {
    VERDICT_OK          = 3'd0,
    VERDICT_SHORT_HDR   = 3'd1,
    VERDICT_VERSION     = 3'd2,
    VERDICT_TYPE        = 3'd3,
    VERDICT_NAME_LONG   = 3'd4,
    VERDICT_SHORT_FRAME = 3'd5,
    VERDICT_PAYLOAD     = 3'd6,
    VERDICT_STATUS      = 3'd7
  } verdict_t;

  typedef enum logic [2:0] {
    REG_EXP_VERSION  = 3'd0,
    REG_MAX_TYPE     = 3'd1,
    REG_ERR_TYPE     = 3'd2,
    REG_MAX_ERR_STAT = 3'd3,
    REG_UNSPEC_STAT  = 3'd4,
    REG_MAX_NAME_LEN = 3'd5,
    REG_FLAG_MASK    = 3'd6
  } reg_idx_t;

endpackage

// ===== rtl/core/rfhc_if.sv =====
interface rfhc_in_if;
  import rfhc_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface rfhc_out_if;
  import rfhc_pkg::*;

  logic        valid;
  logic        ready;
  verdict_t    verdict;
  logic [7:0]  frame_type;
  logic [7:0]  frame_status;
  logic [23:0] frame_flags;
  logic [31:0] name_length;
  logic [31:0] error_length;
  logic [63:0] payload_length;

  modport source (output valid, output verdict, output frame_type, output frame_status,
                  output frame_flags, output name_length, output error_length,
                  output payload_length, input ready);
  modport sink (input valid, input verdict, input frame_type, input frame_status,
                input frame_flags, input name_length, input error_length,
                input payload_length, output ready);
endinterface

// ===== rtl/core/rpc_frame_header_checker_top.sv =====
// Frame header checker.
// in_ch carries a received frame one byte per transfer, with last_byte set on
// the final byte. The first 22 bytes are the little-endian header (version,
// type, control word with status in the top byte, name, error and payload
// lengths). out_ch carries one result per frame: a verdict code plus the
// decoded fields, all zero unless the verdict is OK.
// Throughput: one byte per cycle while in_ch.ready is high, frames back to
// back with no gap. The byte counter and header capture register take each
// byte; the last byte loads a check register, and the result register is
// loaded from it whenever the result register is empty or being taken.
// When out_ch stalls, the result register holds, one further frame end can
// wait in the check register, and in_ch.ready drops only while both are full.
// The APB port writes the seven limit registers at byte address 4*i; pready is
// always high. Configure only while no frame is in flight.
// Reset (rst_n low, synchronous) empties both stages, clears the byte count
// and loads the register defaults.
module rpc_frame_header_checker_top (
  input  logic                         clk,
  input  logic                         rst_n,
  rfhc_in_if.sink                      in_ch,
  rfhc_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rfhc_pkg::ADDR_W-1:0]  paddr,
  input  logic [rfhc_pkg::DATA_W-1:0]  pwdata,
  output logic [rfhc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import rfhc_pkg::*;

  // configuration registers
  logic [7:0]  exp_version_r;
  logic [7:0]  max_type_r;
  logic [7:0]  err_type_r;
  logic [7:0]  max_err_stat_r;
  logic [7:0]  unspec_stat_r;
  logic [31:0] max_name_bytes_r;
  logic [23:0] flag_mask_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  // capture stage
  logic              in_xfer;
  logic              in_hdr;
  logic [POS_W-1:0]  pos;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_inc;
  logic [7:0]        hdr_r   [HEADER_BYTES];
  logic [7:0]        hdr_cur [HEADER_BYTES];

  // check stage
  logic               chk_vld_r, chk_vld_nxt;
  logic               chk_load;
  logic               chk_adv;
  logic [CNT_W-1:0]   chk_len_r;
  logic [FIXED_W-1:0] chk_fixed_r;
  logic [7:0]         chk_ver_r;
  logic [7:0]         chk_type_r;
  logic [31:0]        chk_ctrl_r;
  logic [31:0]        chk_name_r;
  logic [31:0]        chk_err_r;
  logic [63:0]        chk_pay_r;

  logic [7:0]         status;
  logic [CNT_W-1:0]   fixed_ext;
  logic [CNT_W-1:0]   remain;
  verdict_t           verdict;
  logic [7:0]         ostatus;

  // result stage
  logic        out_vld_r, out_vld_nxt;
  verdict_t    out_verdict_r;
  logic [7:0]  out_type_r;
  logic [7:0]  out_status_r;
  logic [23:0] out_flags_r;
  logic [31:0] out_name_r;
  logic [31:0] out_err_r;
  logic [63:0] out_pay_r;

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_version_r    <= 8'd1;
      max_type_r       <= 8'd3;
      err_type_r       <= 8'd2;
      max_err_stat_r   <= 8'd8;
      unspec_stat_r    <= 8'd255;
      max_name_bytes_r <= 32'd256;
      flag_mask_r      <= 24'hFFFFFF;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_EXP_VERSION:  exp_version_r    <= pwdata[7:0];
        REG_MAX_TYPE:     max_type_r       <= pwdata[7:0];
        REG_ERR_TYPE:     err_type_r       <= pwdata[7:0];
        REG_MAX_ERR_STAT: max_err_stat_r   <= pwdata[7:0];
        REG_UNSPEC_STAT:  unspec_stat_r    <= pwdata[7:0];
        REG_MAX_NAME_LEN: max_name_bytes_r <= pwdata[31:0];
        REG_FLAG_MASK:    flag_mask_r      <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_EXP_VERSION:  prdata = {24'd0, exp_version_r};
      REG_MAX_TYPE:     prdata = {24'd0, max_type_r};
      REG_ERR_TYPE:     prdata = {24'd0, err_type_r};
      REG_MAX_ERR_STAT: prdata = {24'd0, max_err_stat_r};
      REG_UNSPEC_STAT:  prdata = {24'd0, unspec_stat_r};
      REG_MAX_NAME_LEN: prdata = max_name_bytes_r;
      REG_FLAG_MASK:    prdata = {8'd0, flag_mask_r};
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- capture
  assign chk_adv     = chk_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !chk_vld_r || chk_adv;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign chk_load    = in_xfer && in_ch.last_byte;

  assign in_hdr  = (cnt_r < CNT_W'(HEADER_BYTES));
  assign pos     = cnt_r[POS_W-1:0];
  // saturate at all ones
  assign cnt_inc = (&cnt_r) ? cnt_r : cnt_r + CNT_W'(1);

  always_comb begin
    for (int i = 0; i < HEADER_BYTES; i++) begin
      hdr_cur[i] = (in_hdr && pos == POS_W'(i)) ? in_ch.frame_byte : hdr_r[i];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_xfer) begin
      cnt_nxt = in_ch.last_byte ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Header bytes past the count are stale from the previous frame; the short
  // header verdict masks them.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      hdr_r <= hdr_cur;
    end
  end

  // ---------------------------------------------------------------- check
  always_comb begin
    chk_vld_nxt = chk_vld_r;
    if (chk_load) begin
      chk_vld_nxt = 1'b1;
    end else if (chk_adv) begin
      chk_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_vld_r <= 1'b0;
    end else begin
      chk_vld_r <= chk_vld_nxt;
    end
  end

  // Name and error lengths are complete in hdr_r whenever the frame is long
  // enough for the sum to matter.
  always_ff @(posedge clk) begin
    if (chk_load) begin
      chk_len_r   <= cnt_inc;
      chk_fixed_r <= FIXED_W'(HEADER_BYTES)
                   + FIXED_W'({hdr_r[OFS_NAME+3], hdr_r[OFS_NAME+2],
                               hdr_r[OFS_NAME+1], hdr_r[OFS_NAME]})
                   + FIXED_W'({hdr_r[OFS_ERROR+3], hdr_r[OFS_ERROR+2],
                               hdr_r[OFS_ERROR+1], hdr_r[OFS_ERROR]});
      chk_ver_r   <= hdr_cur[OFS_VERSION];
      chk_type_r  <= hdr_cur[OFS_TYPE];
      chk_ctrl_r  <= {hdr_cur[OFS_CTRL+3], hdr_cur[OFS_CTRL+2],
                      hdr_cur[OFS_CTRL+1], hdr_cur[OFS_CTRL]};
      chk_name_r  <= {hdr_cur[OFS_NAME+3], hdr_cur[OFS_NAME+2],
                      hdr_cur[OFS_NAME+1], hdr_cur[OFS_NAME]};
      chk_err_r   <= {hdr_cur[OFS_ERROR+3], hdr_cur[OFS_ERROR+2],
                      hdr_cur[OFS_ERROR+1], hdr_cur[OFS_ERROR]};
      chk_pay_r   <= {hdr_cur[OFS_PAYLOAD+7], hdr_cur[OFS_PAYLOAD+6],
                      hdr_cur[OFS_PAYLOAD+5], hdr_cur[OFS_PAYLOAD+4],
                      hdr_cur[OFS_PAYLOAD+3], hdr_cur[OFS_PAYLOAD+2],
                      hdr_cur[OFS_PAYLOAD+1], hdr_cur[OFS_PAYLOAD]};
    end
  end

  assign status    = chk_ctrl_r[31:24];
  assign fixed_ext = CNT_W'(chk_fixed_r);
  assign remain    = chk_len_r - fixed_ext;

  // first failing rule wins
  always_comb begin
    verdict = VERDICT_OK;
    ostatus = 8'd0;
    if (chk_len_r < CNT_W'(HEADER_BYTES)) begin
      verdict = VERDICT_SHORT_HDR;
    end else if (chk_ver_r != exp_version_r) begin
      verdict = VERDICT_VERSION;
    end else if (chk_type_r > max_type_r) begin
      verdict = VERDICT_TYPE;
    end else if (chk_name_r > max_name_bytes_r) begin
      verdict = VERDICT_NAME_LONG;
    end else if (chk_len_r < fixed_ext) begin
      verdict = VERDICT_SHORT_FRAME;
    end else if (chk_pay_r != remain) begin
      verdict = VERDICT_PAYLOAD;
    end else if (chk_type_r == err_type_r) begin
      if (status > max_err_stat_r || chk_err_r == 32'd0) begin
        verdict = VERDICT_STATUS;
      end else begin
        ostatus = (status != 8'd0) ? status : unspec_stat_r;
      end
    end else if (status != 8'd0 || chk_err_r != 32'd0) begin
      verdict = VERDICT_STATUS;
    end
  end

  // ---------------------------------------------------------------- result
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (chk_adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (chk_adv) begin
      out_verdict_r <= verdict;
      if (verdict == VERDICT_OK) begin
        out_type_r   <= chk_type_r;
        out_status_r <= ostatus;
        out_flags_r  <= chk_ctrl_r[23:0] & flag_mask_r;
        out_name_r   <= chk_name_r;
        out_err_r    <= chk_err_r;
        out_pay_r    <= chk_pay_r;
      end else begin
        out_type_r   <= '0;
        out_status_r <= '0;
        out_flags_r  <= '0;
        out_name_r   <= '0;
        out_err_r    <= '0;
        out_pay_r    <= '0;
      end
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.verdict        = out_verdict_r;
  assign out_ch.frame_type     = out_type_r;
  assign out_ch.frame_status   = out_status_r;
  assign out_ch.frame_flags    = out_flags_r;
  assign out_ch.name_length    = out_name_r;
  assign out_ch.error_length   = out_err_r;
  assign out_ch.payload_length = out_pay_r;

endmodule

// ===== rtl/core/rfhc_checker.sv =====
module rfhc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  verdict,
  input logic [7:0]  frame_type,
  input logic [7:0]  frame_status,
  input logic [23:0] frame_flags,
  input logic [31:0] name_length,
  input logic [31:0] error_length,
  input logic [63:0] payload_length
);
  import rfhc_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(verdict) && $stable(payload_length)
      && $stable(name_length) && $stable(frame_flags))
    else $error("stalled result changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && verdict != VERDICT_OK |-> frame_type == 8'd0
      && frame_status == 8'd0 && frame_flags == 24'd0 && name_length == 32'd0
      && error_length == 32'd0 && payload_length == 64'd0)
    else $error("failed frame carries nonzero fields");

  a_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_status != 8'd0 |-> verdict == VERDICT_OK)
    else $error("status reported on a failed frame");

  // a fresh result follows the transfer of a last byte
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
    else $error("result without a frame end");

endmodule

bind rpc_frame_header_checker_top rfhc_checker u_rfhc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_last        (in_ch.last_byte),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .verdict        (out_ch.verdict),
  .frame_type     (out_ch.frame_type),
  .frame_status   (out_ch.frame_status),
  .frame_flags    (out_ch.frame_flags),
  .name_length    (out_ch.name_length),
  .error_length   (out_ch.error_length),
  .payload_length (out_ch.payload_length)
);

// ===== test/frame_verdict_checker.sv =====
module frame_verdict_checker
  import rfhc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  rfhc_in_if                in_mon,
  rfhc_out_if               out_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending
);

  typedef struct {
    verdict_t    verdict;
    logic [7:0]  ftype;
    logic [7:0]  status;
    logic [23:0] flags;
    logic [31:0] name_bytes;
    logic [31:0] err_len;
    logic [63:0] payload_bytes;
  } frame_result_t;

  frame_result_t expected_results[$];
  int            mismatches;

  // limit registers as last written over the bus
  logic [7:0]  exp_version;
  logic [7:0]  max_type;
  logic [7:0]  err_type;
  logic [7:0]  max_err_status;
  logic [7:0]  unspec_status;
  logic [31:0] max_name_bytes;
  logic [23:0] flag_mask;

  // header of the frame in flight
  logic [63:0] rx_count;
  logic [7:0]  rx_version;
  logic [7:0]  rx_type;
  logic [31:0] rx_control;
  logic [31:0] rx_name_bytes;
  logic [31:0] rx_err_len;
  logic [63:0] rx_payload_bytes;

  function automatic void clear_frame();
    rx_count         = '0;
    rx_version       = '0;
    rx_type          = '0;
    rx_control       = '0;
    rx_name_bytes    = '0;
    rx_err_len       = '0;
    rx_payload_bytes = '0;
  endfunction

  function automatic void take_byte(input logic [7:0] b);
    int unsigned pos;
    if (rx_count < 64'(HEADER_BYTES)) begin
      pos = int'(rx_count);
      if (pos == OFS_VERSION) rx_version = b;
      else if (pos == OFS_TYPE) rx_type = b;
      else if (pos < OFS_NAME) rx_control[8*(pos-OFS_CTRL) +: 8] = b;
      else if (pos < OFS_ERROR) rx_name_bytes[8*(pos-OFS_NAME) +: 8] = b;
      else if (pos < OFS_PAYLOAD) rx_err_len[8*(pos-OFS_ERROR) +: 8] = b;
      else rx_payload_bytes[8*(pos-OFS_PAYLOAD) +: 8] = b;
    end
    // saturate rather than wrap on absurdly long frames
    if (rx_count != '1) rx_count++;
  endfunction

  function automatic frame_result_t judge_frame();
    frame_result_t r;
    logic [64:0]   fixed_sum;
    logic [7:0]    status;
    r.verdict       = VERDICT_OK;
    r.ftype         = '0;
    r.status        = '0;
    r.flags         = '0;
    r.name_bytes    = '0;
    r.err_len       = '0;
    r.payload_bytes = '0;
    fixed_sum = 65'(HEADER_BYTES) + 65'(rx_name_bytes) + 65'(rx_err_len);
    status    = rx_control[31:24];
    if (rx_count < 64'(HEADER_BYTES)) r.verdict = VERDICT_SHORT_HDR;
    else if (rx_version != exp_version) r.verdict = VERDICT_VERSION;
    else if (rx_type > max_type) r.verdict = VERDICT_TYPE;
    else if (rx_name_bytes > max_name_bytes) r.verdict = VERDICT_NAME_LONG;
    else if ({1'b0, rx_count} < fixed_sum) r.verdict = VERDICT_SHORT_FRAME;
    else if (rx_payload_bytes != rx_count - fixed_sum[63:0]) r.verdict = VERDICT_PAYLOAD;
    else if (rx_type == err_type) begin
      if (status > max_err_status || rx_err_len == '0) r.verdict = VERDICT_STATUS;
      else r.status = (status != '0) ? status : unspec_status;
    end else if (status != '0 || rx_err_len != '0) begin
      r.verdict = VERDICT_STATUS;
    end
    if (r.verdict == VERDICT_OK) begin
      r.ftype         = rx_type;
      r.flags         = rx_control[23:0] & flag_mask;
      r.name_bytes    = rx_name_bytes;
      r.err_len       = rx_err_len;
      r.payload_bytes = rx_payload_bytes;
    end else begin
      r.status = '0;
    end
    return r;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      exp_version    = 8'd1;
      max_type       = 8'd3;
      err_type       = 8'd2;
      max_err_status = 8'd8;
      unspec_status  = 8'd255;
      max_name_bytes = 32'd256;
      flag_mask      = 24'hFF_FFFF;
      clear_frame();
      expected_results.delete();
      mismatches = 0;
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_EXP_VERSION:  exp_version    = pwdata[7:0];
          REG_MAX_TYPE:     max_type       = pwdata[7:0];
          REG_ERR_TYPE:     err_type       = pwdata[7:0];
          REG_MAX_ERR_STAT: max_err_status = pwdata[7:0];
          REG_UNSPEC_STAT:  unspec_status  = pwdata[7:0];
          REG_MAX_NAME_LEN: max_name_bytes = pwdata[31:0];
          REG_FLAG_MASK:    flag_mask      = pwdata[23:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual verdict %0d",
                   $time, out_mon.verdict);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("verdict", 64'(want.verdict), 64'(out_mon.verdict));
          check_field("frame_type", 64'(want.ftype), 64'(out_mon.frame_type));
          check_field("frame_status", 64'(want.status), 64'(out_mon.frame_status));
          check_field("frame_flags", 64'(want.flags), 64'(out_mon.frame_flags));
          check_field("name_length", 64'(want.name_bytes), 64'(out_mon.name_length));
          check_field("error_length", 64'(want.err_len), 64'(out_mon.error_length));
          check_field("payload_length", want.payload_bytes, out_mon.payload_length);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        take_byte(in_mon.frame_byte);
        if (in_mon.last_byte) begin
          expected_results.push_back(judge_frame());
          clear_frame();
        end
      end
      fail_count <= mismatches;
      pending    <= expected_results.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  import rfhc_pkg::*;

  localparam int unsigned UNMAPPED_REG    = 7;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned MAX_GAP         = 11;
  localparam int unsigned DRAIN_CYCLES    = 4;
  localparam int unsigned TARGET_BYTES    = 100;
  localparam int unsigned TARGET_FRAMES   = 6;
  localparam int unsigned FRAMES_PER_CFG  = 3;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                fail_count;
  int                pending;

  rfhc_in_if  in_ch();
  rfhc_out_if out_ch();

  rpc_frame_header_checker_top u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  frame_verdict_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // register values the stimulus shapes its frames around
  logic [7:0]  cur_version;
  logic [7:0]  cur_max_type;
  logic [7:0]  cur_err_type;
  logic [7:0]  cur_max_status;
  logic [31:0] cur_max_name;

  logic [7:0]  frame_bytes[$];
  int unsigned bytes_sent;
  int unsigned frames_sent;
  int unsigned idle_cycles;
  bit          hold_off_req;
  bit          in_steady;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result receiver: random back-pressure plus one long hold-off on request
  initial begin
    int unsigned gap;
    bit          steady;
    steady = 1'b0;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      if ($urandom_range(0, 15) == 0) steady = !steady;
      gap = steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    apb_write(ADDR_W'(4 * idx), value);
    case (idx)
      REG_EXP_VERSION:  cur_version    = value[7:0];
      REG_MAX_TYPE:     cur_max_type   = value[7:0];
      REG_ERR_TYPE:     cur_err_type   = value[7:0];
      REG_MAX_ERR_STAT: cur_max_status = value[7:0];
      REG_MAX_NAME_LEN: cur_max_name   = value[31:0];
      default: ;
    endcase
  endtask

  task automatic program_all(input logic [7:0] ver, input logic [7:0] mtype,
                             input logic [7:0] etype, input logic [7:0] mstat,
                             input logic [7:0] ustat, input logic [31:0] mname,
                             input logic [23:0] fmask);
    set_reg(REG_EXP_VERSION, 32'(ver));
    set_reg(REG_MAX_TYPE, 32'(mtype));
    set_reg(REG_ERR_TYPE, 32'(etype));
    set_reg(REG_MAX_ERR_STAT, 32'(mstat));
    set_reg(REG_UNSPEC_STAT, 32'(ustat));
    set_reg(REG_MAX_NAME_LEN, mname);
    set_reg(REG_FLAG_MASK, 32'(fmask));
  endtask

  // drop valid, let every verdict come out and the result stage empty
  task automatic drain();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input bit last, input bit no_gap);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) in_steady = !in_steady;
    gap = (no_gap || in_steady) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.frame_byte <= b;
    in_ch.last_byte  <= last;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_frame(input bit no_gap);
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1, no_gap);
    frames_sent++;
  endtask

  // header little-endian in the first bytes, random body after it
  task automatic send_header_frame(input logic [7:0] ver, input logic [7:0] typ,
                                   input logic [7:0] st, input logic [23:0] flags,
                                   input logic [31:0] nl, input logic [31:0] el,
                                   input logic [63:0] pl, input int unsigned total);
    logic [175:0] hdr;
    hdr = {pl, el, nl, st, flags, typ, ver};
    frame_bytes.delete();
    for (int unsigned i = 0; i < total; i++)
      frame_bytes.push_back(i < HEADER_BYTES ? hdr[8*i +: 8] : 8'($urandom));
    send_frame(1'b0);
  endtask

  function automatic int unsigned fit(input logic [31:0] nl, input logic [31:0] el,
                                      input logic [63:0] pl);
    return HEADER_BYTES + nl + el + 32'(pl);
  endfunction

  task automatic random_frame();
    logic [7:0]  ver;
    logic [7:0]  typ;
    logic [7:0]  st;
    logic [23:0] flags;
    logic [31:0] nl;
    logic [31:0] el;
    logic [63:0] pl;
    int unsigned total;
    int unsigned name_cap;
    int unsigned kind;
    ver = cur_version;
    typ = ($urandom_range(0, 2) == 0) ? cur_err_type : 8'($urandom_range(0, cur_max_type));
    name_cap = (cur_max_name < 6) ? cur_max_name : 6;
    nl = $urandom_range(0, name_cap);
    if (typ == cur_err_type) begin
      el = $urandom_range(1, 6);
      st = $urandom_range(0, cur_max_status);
    end else begin
      el = '0;
      st = '0;
    end
    pl    = $urandom_range(0, 8);
    flags = $urandom;
    total = fit(nl, el, pl);
    kind  = $urandom_range(0, 9);
    if (kind == 6) begin
      total = $urandom_range(1, HEADER_BYTES - 1);
    end else if (kind == 7) begin
      case ($urandom_range(0, 5))
        0: ver = ver ^ 8'($urandom_range(1, 255));
        1: typ = $urandom;
        2: nl = (cur_max_name != '1) ? cur_max_name + $urandom_range(1, 4) : $urandom;
        3: if (nl + el > 0) total = HEADER_BYTES + nl + el - $urandom_range(1, nl + el);
        4: pl = {$urandom, $urandom};
        default: begin
          st    = $urandom;
          el    = $urandom_range(0, 3);
          total = fit(nl, el, pl);
        end
      endcase
    end else if (kind == 8) begin
      total = total + $urandom_range(1, 3);
    end else if (kind == 9) begin
      ver   = $urandom;
      typ   = $urandom;
      st    = $urandom;
      nl    = $urandom;
      el    = $urandom;
      pl    = {$urandom, $urandom};
      total = $urandom_range(HEADER_BYTES, 40);
    end
    send_header_frame(ver, typ, st, flags, nl, el, pl, total);
  endtask

  task automatic random_config();
    logic [7:0] mtype;
    mtype = $urandom;
    program_all($urandom, mtype,
                ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, mtype)),
                $urandom, $urandom,
                ($urandom_range(0, 4) == 0) ? 32'($urandom) : 32'($urandom_range(0, 300)),
                $urandom);
  endtask

  initial begin
    int unsigned base_bytes;
    int unsigned base_frames;
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.frame_byte = '0;
    in_ch.last_byte  = 1'b0;
    hold_off_req     = 1'b0;
    in_steady        = 1'b0;
    bytes_sent       = 0;
    frames_sent      = 0;
    cur_version      = 8'd1;
    cur_max_type     = 8'd3;
    cur_err_type     = 8'd2;
    cur_max_status   = 8'd8;
    cur_max_name     = 32'd256;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames against the reset limits
    send_header_frame(1, 0, 0, 0, 0, 0, 0, 1);
    send_header_frame(1, 0, 0, 0, 0, 0, 0, HEADER_BYTES - 1);
    send_header_frame(1, 0, 0, 24'hFF_FFFF, 3, 0, 2, fit(3, 0, 2));
    send_header_frame(1, 3, 0, 24'h5A_5A5A, 0, 0, 0, fit(0, 0, 0));
    send_header_frame(1, 2, 0, 24'h00_0001, 2, 4, 1, fit(2, 4, 1));
    send_header_frame(1, 2, 8, 24'h80_0000, 0, 1, 0, fit(0, 1, 0));
    send_header_frame(1, 2, 9, 0, 0, 1, 0, fit(0, 1, 0));
    send_header_frame(1, 2, 3, 0, 0, 0, 0, fit(0, 0, 0));
    send_header_frame(0, 0, 0, 0, 0, 0, 0, fit(0, 0, 0));
    send_header_frame(255, 0, 0, 0, 0, 0, 0, fit(0, 0, 0));
    send_header_frame(1, 4, 0, 0, 0, 0, 0, fit(0, 0, 0));
    send_header_frame(1, 255, 0, 0, 0, 0, 0, fit(0, 0, 0));
    send_header_frame(1, 0, 0, 0, 257, 0, 0, fit(0, 0, 0));
    send_header_frame(1, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, fit(0, 0, 0));
    // name length right at the limit passes the name rule, then runs short
    send_header_frame(1, 1, 0, 24'h12_3456, 256, 0, 0, HEADER_BYTES + 3);
    send_header_frame(1, 0, 0, 0, 10, 0, 0, HEADER_BYTES + 3);
    send_header_frame(1, 2, 1, 0, 0, 32'hFFFF_FFFF, 0, HEADER_BYTES + 8);
    send_header_frame(1, 0, 0, 0, 0, 0, 3, fit(0, 0, 2));
    send_header_frame(1, 0, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, fit(0, 0, 0));
    send_header_frame(1, 1, 1, 0, 0, 0, 0, fit(0, 0, 0));
    send_header_frame(1, 1, 0, 0, 0, 1, 0, fit(0, 1, 0));

    // hold the result side off while tiny frames keep coming
    hold_off_req = 1'b1;
    repeat (12) begin
      frame_bytes.delete();
      repeat ($urandom_range(1, 3)) frame_bytes.push_back($urandom);
      send_frame(1'b1);
    end
    drain();

    // extreme limit settings; the unmapped write must change nothing
    apb_write(ADDR_W'(4 * UNMAPPED_REG), '1);
    program_all(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 32'hFFFF_FFFF, 24'h00_0000);
    repeat (3) random_frame();
    drain();
    program_all(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 32'h0, 24'hFF_FFFF);
    repeat (3) random_frame();
    drain();

    base_bytes  = bytes_sent;
    base_frames = frames_sent;
    while (bytes_sent - base_bytes < TARGET_BYTES || frames_sent - base_frames < TARGET_FRAMES)
    begin
      if ((frames_sent - base_frames) % FRAMES_PER_CFG == 0) begin
        drain();
        if (frames_sent == base_frames) program_all(1, 3, 2, 8, 255, 256, 24'hFF_FFFF);
        else random_config();
      end
      random_frame();
    end
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
